// ===== design/lowest_free_block_allocator_unit_macros.svh =====
// ============================================================================
// Assertion macros for the lowest free block allocator
// Shared concurrent assertion forms used by the checker.
// ============================================================================
`ifndef LOWEST_FREE_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define LOWEST_FREE_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LFBA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfba assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LFBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfba assertion failed");

`endif

// ===== design/lfba_pkg.sv =====
// ============================================================================
// lfba_pkg
// Shared widths, request and status codes for the block allocator.
// ============================================================================
`default_nettype none

package lfba_pkg;

    // Capacity of the used list.
    localparam int MAX_USED = 256;
    localparam int IDX_W    = $clog2(MAX_USED);
    localparam int CNT_W    = $clog2(MAX_USED + 1);

    localparam int DATA_W   = 32;
    localparam int REQ_W    = 2;
    localparam int STAT_W   = 2;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_FREE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam logic REG_BLOCK_COUNT = 1'b0;

endpackage

`default_nettype wire

// ===== design/lfba_if.sv =====
// ============================================================================
// lfba channel interfaces
// Valid/ready channels for requests and responses of the allocator.
// ============================================================================
`default_nettype none

interface lfba_req_if;
    logic                              valid;
    logic                              ready;
    logic [lfba_pkg::REQ_W-1:0]        req_type;
    logic [lfba_pkg::DATA_W-1:0]       block_index;

    modport source (output valid, output req_type, output block_index, input ready);
    modport sink   (input valid, input req_type, input block_index, output ready);
endinterface

interface lfba_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [lfba_pkg::STAT_W-1:0]       status;
    logic [lfba_pkg::DATA_W-1:0]       free_index;
    logic [lfba_pkg::CNT_W-1:0]        used_count;

    modport source (output valid, output status, output free_index, output used_count,
                    input ready);
    modport sink   (input valid, input status, input free_index, input used_count,
                    output ready);
endinterface

`default_nettype wire

// ===== design/lfba_ram.sv =====
// ============================================================================
// lfba_ram
// Simple dual-port RAM: one write port, one registered read port.
// ============================================================================
`default_nettype none

module lfba_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/lowest_free_block_allocator_unit.sv =====
// ============================================================================
// lowest_free_block_allocator_unit
// Keeps a bounded list of used block indexes and hands out the lowest free one.
// ============================================================================
//
//  Channel   Direction  Handshake        Beat contents
//  -------   ---------  ---------------  --------------------------------------
//  req       in         valid / ready    req_type, block_index
//  rsp       out        valid / ready    status, free_index, used_count
//  apb       in         psel / penable   block_count register at byte 0
//
// Add, clear and unknown requests are accepted in S_IDLE and pass through
// S_EMIT, which hands the result to the output register. An allocate request
// makes two passes over a list of L entries: one pass reads every list
// entry out of the list RAM (one read port, one entry a cycle) to mark the
// small values seen, and a second pass walks the seen map one index a cycle
// until it finds the first unmarked index. req.ready is high only while the
// sequencer is idle. A result waiting in the output register does not block
// the next request; a new result waits in its own state until the output
// register is free. Reset clears the list length, the sequencer and the
// block_count register; the list contents stay undefined, which is harmless
// because only entries below the list length are ever read.
//
`default_nettype none

module lowest_free_block_allocator_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    lfba_req_if.sink                              req,
    lfba_rsp_if.source                            rsp,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [lfba_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [lfba_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [lfba_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready
);

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    localparam int IDX_W  = lfba_pkg::IDX_W;
    localparam int CNT_W  = lfba_pkg::CNT_W;
    localparam int DATA_W = lfba_pkg::DATA_W;
    localparam logic [CNT_W-1:0] LIST_FULL = CNT_W'(lfba_pkg::MAX_USED);

    logic [1:0]                   state_reg, state_next;
    logic [CNT_W-1:0]             len_reg, len_next;
    logic [CNT_W-1:0]             ptr_reg, ptr_next;
    logic                         rd_vld_reg, rd_vld_next;
    logic [lfba_pkg::MAX_USED-1:0] seen_reg, seen_next;
    logic [DATA_W-1:0]            block_count_reg;

    logic [lfba_pkg::STAT_W-1:0]  pend_status_reg, pend_status_next;
    logic [DATA_W-1:0]            pend_index_reg, pend_index_next;

    logic                         out_valid_reg, out_valid_next;
    logic [lfba_pkg::STAT_W-1:0]  out_status_reg, out_status_next;
    logic [DATA_W-1:0]            out_index_reg, out_index_next;
    logic [CNT_W-1:0]             out_count_reg, out_count_next;

    logic                         mem_we;
    logic [DATA_W-1:0]            mem_wdata;
    logic                         mem_re;
    logic [DATA_W-1:0]            mem_rdata;

    logic                         cfg_write;
    logic                         scan_hit;

    // ------------------------------------------------------------------------
    // Configuration port. Only bit 2 of the address selects a register, so
    // every write lands in a well defined place.
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        if (paddr[2] == lfba_pkg::REG_BLOCK_COUNT)
        begin
            prdata = block_count_reg;
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= '0;
        end
        else if (cfg_write && (paddr[2] == lfba_pkg::REG_BLOCK_COUNT))
        begin
            block_count_reg <= pwdata;
        end
    end

    // ------------------------------------------------------------------------
    // Used list storage. Writes go to the entry at the current list length;
    // reads walk the list during an allocate.
    // ------------------------------------------------------------------------
    lfba_ram #(
        .DEPTH (lfba_pkg::MAX_USED),
        .WIDTH (DATA_W)
    ) u_list_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (len_reg[IDX_W-1:0]),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (ptr_reg[IDX_W-1:0]),
        .rdata (mem_rdata)
    );

    // The scan stops at the list length, or at the first index never seen.
    assign scan_hit = (ptr_reg == len_reg) || !seen_reg[ptr_reg[IDX_W-1:0]];

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        len_next         = len_reg;
        ptr_next         = ptr_reg;
        seen_next        = seen_reg;
        pend_status_next = pend_status_reg;
        pend_index_next  = pend_index_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_index_next   = out_index_reg;
        out_count_next   = out_count_reg;
        mem_we           = 1'b0;
        mem_wdata        = req.block_index;
        mem_re           = 1'b0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    pend_status_next = lfba_pkg::ST_OK;
                    pend_index_next  = '0;
                    state_next       = S_EMIT;
                    case (req.req_type)
                        lfba_pkg::REQ_ADD:
                        begin
                            if (len_reg == LIST_FULL)
                            begin
                                pend_status_next = lfba_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we   = 1'b1;
                                len_next = len_reg + 1'b1;
                            end
                        end
                        lfba_pkg::REQ_ALLOC:
                        begin
                            seen_next  = '0;
                            ptr_next   = '0;
                            state_next = S_READ;
                        end
                        lfba_pkg::REQ_CLEAR:
                        begin
                            len_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_READ:
            begin
                // Mark the entry read in the previous cycle when it can matter.
                if (rd_vld_reg && (mem_rdata < DATA_W'(len_reg)))
                begin
                    seen_next[mem_rdata[IDX_W-1:0]] = 1'b1;
                end
                if (ptr_reg != len_reg)
                begin
                    mem_re   = 1'b1;
                    ptr_next = ptr_reg + 1'b1;
                end
                else if (!rd_vld_reg)
                begin
                    ptr_next   = '0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = S_EMIT;
                    if (DATA_W'(ptr_reg) >= block_count_reg)
                    begin
                        pend_status_next = lfba_pkg::ST_NO_FREE;
                    end
                    else if (len_reg == LIST_FULL)
                    begin
                        pend_status_next = lfba_pkg::ST_FULL;
                    end
                    else
                    begin
                        mem_we          = 1'b1;
                        mem_wdata       = DATA_W'(ptr_reg);
                        len_next        = len_reg + 1'b1;
                        pend_index_next = DATA_W'(ptr_reg);
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            S_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_index_next  = pend_index_reg;
                    out_count_next  = len_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rd_vld_next = mem_re;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg         <= ptr_next;
        seen_reg        <= seen_next;
        pend_status_reg <= pend_status_next;
        pend_index_reg  <= pend_index_next;
        out_status_reg  <= out_status_next;
        out_index_reg   <= out_index_next;
        out_count_reg   <= out_count_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.free_index = out_index_reg;
    assign rsp.used_count = out_count_reg;

endmodule

`default_nettype wire

// ===== design/lfba_checker.sv =====
// ============================================================================
// lfba_checker
// Port-level assertions for the lowest free block allocator.
// ============================================================================
`default_nettype none

`include "lowest_free_block_allocator_unit_macros.svh"

module lfba_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic [lfba_pkg::STAT_W-1:0]   rsp_status,
    input wire logic [lfba_pkg::DATA_W-1:0]   rsp_free_index,
    input wire logic [lfba_pkg::CNT_W-1:0]    rsp_used_count
);

    // A stalled response keeps its payload.
    `LFBA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_free_index) && $stable(rsp_used_count))

    // The list never grows past its capacity.
    `LFBA_ASSERT_NOW(a_count_bound, clk, rst_n, rsp_valid, rsp_used_count <= lfba_pkg::CNT_W'(lfba_pkg::MAX_USED))

    // A failed request never reports an allocated index.
    `LFBA_ASSERT_NOW(a_fail_zero, clk, rst_n, rsp_valid && (rsp_status != lfba_pkg::ST_OK), rsp_free_index == '0)

    // An allocated index was appended, so it lies below the new list length.
    `LFBA_ASSERT_NOW(a_alloc_in_list, clk, rst_n, rsp_valid && (rsp_free_index != '0), lfba_pkg::DATA_W'(rsp_used_count) > rsp_free_index)

endmodule

bind lowest_free_block_allocator_unit lfba_checker u_lfba_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_free_index (rsp.free_index),
    .rsp_used_count (rsp.used_count)
);

`default_nettype wire
